// ===== src/buffered_uart_transmitter_core_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef BUFFERED_UART_TRANSMITTER_CORE_MACROS_SVH
`define BUFFERED_UART_TRANSMITTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BUTX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BUTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/butx_pkg.sv =====
// shared types and constants for the buffered uart transmitter
// no dependencies
package butx_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int LEVEL_W        = 5;
    localparam int BYTE_W         = 8;

    // bit index: 0..7 data bit next, stop bit next, frame finished
    localparam logic [3:0] BIT_STOP = 4'd8;
    localparam logic [3:0] BIT_DONE = 4'd9;

    localparam logic       LINE_IDLE  = 1'b1;
    localparam logic       LINE_START = 1'b0;
    localparam logic [BYTE_W-1:0] SHIFT_RESET = 8'hff;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic               tx_line;
        logic               push_rejected;
        logic               ticking;
        logic [LEVEL_W-1:0] fifo_level;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    // command queue head as seen by the engine
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_if;

endpackage

// ===== src/butx_front.sv =====
// front end: accepts input items, decodes op and queues commands
// depends on butx_pkg
module butx_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  butx_pkg::t_in_item i_in_item,
    output butx_pkg::t_cmd_if  o_cmd,
    input  logic               i_pop
);
    import butx_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    assign o_in_stall = (r_cnt == 2'(QD));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    always_comb begin
        w_cmd.op   = t_op'(i_in_item.op);
        w_cmd.data = i_in_item.data_byte;
    end

    always_comb begin
        n_cnt = r_cnt;
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

endmodule

// ===== src/butx_engine.sv =====
// back end: byte fifo, frame shifter and result register
// depends on butx_pkg
module butx_engine #(
    parameter int FIFO_DEPTH = butx_pkg::FIFO_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  butx_pkg::t_cmd_if   i_cmd,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output butx_pkg::t_out_item o_out_item
);
    import butx_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    logic [BYTE_W-1:0] r_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [3:0]        r_bit_idx, n_bit_idx;
    logic              r_line, n_line;
    logic              r_enabled, n_enabled;
    logic              w_rejected;
    logic              w_wr_en;
    logic              w_fire;
    logic              r_out_valid;
    t_out_item         r_out_item;

    // the engine takes a command whenever the result slot is free or draining
    assign w_fire = i_cmd.valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_fire;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_shift    = r_shift;
        n_bit_idx  = r_bit_idx;
        n_line     = r_line;
        n_enabled  = r_enabled;
        w_rejected = 1'b0;
        w_wr_en    = 1'b0;
        if (w_fire) begin
            unique case (i_cmd.cmd.op)
                OP_PUSH: begin
                    if (r_count == FULL_CNT) begin
                        w_rejected = 1'b1;
                    end else begin
                        w_wr_en   = 1'b1;
                        n_tail    = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                        n_count   = r_count + CW'(1);
                        n_enabled = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_enabled) begin
                        if (r_bit_idx < BIT_STOP) begin
                            n_line    = r_shift[0];
                            n_shift   = r_shift >> 1;
                            n_bit_idx = r_bit_idx + 4'd1;
                        end else if (r_bit_idx == BIT_STOP) begin
                            n_line    = LINE_IDLE;
                            n_bit_idx = BIT_DONE;
                        end else if (r_count == '0) begin
                            n_enabled = 1'b0;
                        end else begin
                            // next frame: load byte and drive start bit
                            n_shift   = r_rd_data;
                            n_head    = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                            n_count   = r_count - CW'(1);
                            n_bit_idx = 4'd0;
                            n_line    = LINE_START;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // r_rd_data always holds the entry at the head, write bypass on an empty fifo
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_tail] <= i_cmd.cmd.data;
        end
        if (w_wr_en && (r_tail == n_head)) begin
            r_rd_data <= i_cmd.cmd.data;
        end else begin
            r_rd_data <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_shift     <= SHIFT_RESET;
            r_bit_idx   <= BIT_STOP;
            r_line      <= LINE_IDLE;
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_shift   <= n_shift;
            r_bit_idx <= n_bit_idx;
            r_line    <= n_line;
            r_enabled <= n_enabled;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item.tx_line       <= n_line;
            r_out_item.push_rejected <= w_rejected;
            r_out_item.ticking       <= n_enabled;
            r_out_item.fifo_level    <= LEVEL_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== src/buffered_uart_transmitter_core.sv =====
// channel  direction  valid        stall        payload
// in       input      i_in_valid   o_in_stall   i_in_item  (op, data_byte)
// out      output     o_out_valid  i_out_stall  o_out_item (tx_line, push_rejected,
//                                                           ticking, fifo_level)
//
// one item per clock sustained while i_out_stall is low; from accept to result an item is
// registered in the front command queue, then in the engine's result register
// the engine does one push or tick per cycle unless a stalled result is held; the fifo head byte is prefetched
// from the memory read register so a pop does not wait for a memory read
// reset is synchronous, active low; the line idles high and ticking is off
// a stalled result holds; the two-entry command queue absorbs the input side
// top level: buffered uart transmitter, front queue plus engine
// depends on butx_pkg, butx_front, butx_engine
module buffered_uart_transmitter_core #(
    parameter int FIFO_DEPTH = butx_pkg::FIFO_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  butx_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output butx_pkg::t_out_item o_out_item
);
    import butx_pkg::*;

    t_cmd_if w_cmd;
    logic    w_pop;

    butx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd      (w_cmd),
        .i_pop      (w_pop)
    );

    butx_engine #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/butx_checker.sv =====
// port-level checks for the buffered uart transmitter, bound to the top level
// depends on butx_pkg and buffered_uart_transmitter_core_macros.svh
`include "buffered_uart_transmitter_core_macros.svh"

module butx_checker #(
    parameter int FIFO_DEPTH = butx_pkg::FIFO_DEPTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input butx_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input butx_pkg::t_out_item o_out_item
);
    import butx_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(FIFO_DEPTH);

    `BUTX_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_item), "stalled input transfer changed")
    `BUTX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")
    `BUTX_ASSERT_NOW(a_reject_full, i_clk, i_rst_n, o_out_valid && o_out_item.push_rejected, o_out_item.fifo_level == LEVEL_FULL, "push rejected below full level")
    `BUTX_ASSERT_NOW(a_reject_ticking, i_clk, i_rst_n, o_out_valid && o_out_item.push_rejected, o_out_item.ticking, "full fifo with ticking off")
    `BUTX_ASSERT_NOW(a_idle_high, i_clk, i_rst_n, o_out_valid && !o_out_item.ticking, o_out_item.tx_line, "line low while transmitter idle")

endmodule

bind buffered_uart_transmitter_core butx_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_butx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/buffered_uart_transmitter_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for buffered_uart_transmitter_core: 8n1 frames, fifo, push rejection
// depends on butx_pkg and the core; a clocked driver and monitor with a local line-state predictor
module buffered_uart_transmitter_core_tb;
    import butx_pkg::*;

    localparam int DEPTH      = FIFO_DEPTH_DEF;
    localparam int RAND_ITEMS = 1900;
    localparam int PHASE_LEN  = 200;
    localparam int HOLD_AT    = 600;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_AT   = 1300;
    localparam int TAIL_WAIT  = 20;
    localparam int MAX_REPORT = 10;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // per-phase idle percentages: none, sender, receiver, both
    int sender_idle_pct [4] = '{0, 50, 0, 34};
    int recv_stall_pct  [4] = '{0, 0, 50, 34};

    t_in_item  pending_q [$];
    t_out_item expected_status_q [$];

    int n_total       = 0;
    int n_in_accepted = 0;
    int n_out_checked = 0;
    int n_errors      = 0;
    int hold_cnt      = 0;
    logic hold_done   = 1'b0;

    // predictor state
    logic [BYTE_W-1:0]  tx_mem [DEPTH];
    int                 tx_head;
    int                 tx_tail;
    logic [LEVEL_W-1:0] tx_count;
    logic [BYTE_W-1:0]  tx_shift;
    logic [3:0]         tx_bit;
    logic               tx_line_lvl;
    logic               tx_enabled;

    buffered_uart_transmitter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_out_item next_line_status(input t_in_item it);
        t_out_item st;
        logic      rejected;
        rejected = 1'b0;
        if (it.op == OP_PUSH) begin
            if (tx_count >= DEPTH) begin
                rejected = 1'b1;
            end else begin
                tx_mem[tx_tail] = it.data_byte;
                tx_tail         = (tx_tail + 1) % DEPTH;
                tx_count        = tx_count + 1'b1;
                tx_enabled      = 1'b1;
            end
        end else if (tx_enabled) begin
            if (tx_bit < BIT_STOP) begin
                tx_line_lvl = tx_shift[0];
                tx_shift    = tx_shift >> 1;
                tx_bit      = tx_bit + 1'b1;
            end else if (tx_bit == BIT_STOP) begin
                tx_line_lvl = LINE_IDLE;
                tx_bit      = BIT_DONE;
            end else if (tx_count == 0) begin
                tx_enabled = 1'b0;
            end else begin
                // pop the next byte and drive its start bit
                tx_shift    = tx_mem[tx_head];
                tx_head     = (tx_head + 1) % DEPTH;
                tx_count    = tx_count - 1'b1;
                tx_bit      = '0;
                tx_line_lvl = LINE_START;
            end
        end
        st.tx_line       = tx_line_lvl;
        st.push_rejected = rejected;
        st.ticking       = tx_enabled;
        st.fifo_level    = tx_count;
        return st;
    endfunction

    task automatic log_mismatch(input string what, input t_out_item exp_s,
                                input t_out_item act_s);
        n_errors++;
        if (n_errors <= MAX_REPORT)
            $display("mismatch %0d, %s: expected line=%b rej=%b tick=%b level=%0d, got line=%b rej=%b tick=%b level=%0d",
                     n_errors, what, exp_s.tx_line, exp_s.push_rejected, exp_s.ticking,
                     exp_s.fifo_level, act_s.tx_line, act_s.push_rejected, act_s.ticking,
                     act_s.fifo_level);
    endtask

    task automatic queue_item(input t_op op, input logic [BYTE_W-1:0] data);
        t_in_item it;
        it.op        = op;
        it.data_byte = data;
        pending_q.push_back(it);
    endtask

    // driver: offer the next pending item, hold it while stalled
    always @(posedge i_clk) begin
        int   acc_next;
        int   phase;
        logic accepted;
        logic pausing;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            accepted = in_valid && !o_in_stall;
            acc_next = n_in_accepted + (accepted ? 1 : 0);
            if (accepted) begin
                expected_status_q.push_back(next_line_status(in_item));
                n_in_accepted <= acc_next;
            end
            if (!(in_valid && o_in_stall)) begin
                phase   = (acc_next / PHASE_LEN) % 4;
                // at the drain point hold back until every result is back
                pausing = (acc_next == DRAIN_AT) && (n_out_checked < acc_next);
                if (pending_q.size() != 0 && !pausing &&
                    (hold_cnt != 0 || $urandom_range(0, 99) >= sender_idle_pct[phase])) begin
                    in_item  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the front queue fills and stalls the input
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && n_in_accepted >= HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor: check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_s;
        int        phase;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_status_q.size() == 0) begin
                    log_mismatch("result with nothing expected", '0, o_out_item);
                end else begin
                    exp_s = expected_status_q.pop_front();
                    if (o_out_item.tx_line       !== exp_s.tx_line ||
                        o_out_item.push_rejected !== exp_s.push_rejected ||
                        o_out_item.ticking       !== exp_s.ticking ||
                        o_out_item.fifo_level    !== exp_s.fifo_level)
                        log_mismatch($sformatf("result %0d", n_out_checked), exp_s,
                                     o_out_item);
                    n_out_checked <= n_out_checked + 1;
                end
            end
            phase = (n_in_accepted / PHASE_LEN) % 4;
            out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < recv_stall_pct[phase]);
        end
    end

    initial begin
        int n_rand;
        int seg;
        int len;
        int k;
        tx_head     = 0;
        tx_tail     = 0;
        tx_count    = '0;
        tx_shift    = SHIFT_RESET;
        tx_bit      = BIT_STOP;
        tx_line_lvl = LINE_IDLE;
        tx_enabled  = 1'b0;

        // ticks while disabled, then stop bit before the first pop
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_TICK, 8'hff);
        queue_item(OP_PUSH, 8'h00);
        queue_item(OP_TICK, 8'h5a);
        queue_item(OP_TICK, 8'ha5);
        // fill to the brim while already ticking, then overflow
        queue_item(OP_PUSH, 8'hff);
        queue_item(OP_PUSH, 8'h01);
        queue_item(OP_PUSH, 8'h80);
        queue_item(OP_PUSH, 8'h55);
        queue_item(OP_PUSH, 8'haa);
        for (k = 5; k < DEPTH; k++)
            queue_item(OP_PUSH, 8'(k * 17));
        queue_item(OP_PUSH, 8'hc3);
        queue_item(OP_PUSH, 8'h3c);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_TICK, 8'h00);

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg < 2) begin
                // push burst, long ones overflow the fifo
                len = $urandom_range(1, 20);
                for (k = 0; k < len; k++) queue_item(OP_PUSH, 8'($urandom));
            end else if (seg < 9) begin
                len = $urandom_range(1, 60);
                for (k = 0; k < len; k++) queue_item(OP_TICK, 8'($urandom));
            end else begin
                len = 10;
                for (k = 0; k < len; k++)
                    queue_item(t_op'($urandom_range(0, 1)), 8'($urandom));
            end
            n_rand += len;
        end
        n_total = pending_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_in_accepted == n_total);
        wait (n_out_checked == n_in_accepted);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (expected_status_q.size() != 0)
            log_mismatch("expected result never arrived", expected_status_q[0], '0);
        if (n_errors == 0)
            $display("buffered_uart_transmitter_core regression: pass");
        else
            $display("buffered_uart_transmitter_core regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("buffered_uart_transmitter_core regression: fail");
        $finish;
    end

endmodule
